// ----- rtl/sssg_pkg.sv -----
// ----------------------------------------------------------------------------
// sssg_pkg
// Shared types, widths, codes and the quarter-wave sine table of the stepped
// sine sweep generator.
// ----------------------------------------------------------------------------
package sssg_pkg;

  localparam int unsigned STEP_DEPTH      = 4096;
  localparam int unsigned STEP_ADDR_W     = $clog2(STEP_DEPTH);
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned ROM_SIZE        = 1 << SINE_TABLE_BITS;
  localparam int unsigned LENGTH_BITS     = 24;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned SLOT_W     = 12;
  localparam int unsigned INC_W      = 32;
  localparam int unsigned SLEN_W     = 24;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ROM_W      = 16;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'h7fff;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_RESTART = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_AMPLITUDE  = 1'd0,
    REG_STEP_COUNT = 1'd1
  } reg_e;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] len;
    logic [INC_W-1:0]       inc;
  } step_entry_t;

  localparam int unsigned ENTRY_W = $bits(step_entry_t);

  // pi/2 in q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // restoring division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // midpoint samples of the first quadrant, integer taylor series in q30
  function automatic logic [ROM_SIZE*ROM_W-1:0] sine_rom_init();
    logic [ROM_SIZE*ROM_W-1:0] rom;
    logic [63:0] theta;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] d;
    rom = '0;
    for (int k = 0; k < ROM_SIZE; k++) begin
      theta = (HALF_PI_Q30 * (64'(2 * k) + 64'd1) + 64'(ROM_SIZE)) >> (SINE_TABLE_BITS + 1);
      term  = theta;
      sum   = theta;
      for (int n = 1; n <= 10; n++) begin
        d    = 64'((2 * n) * (2 * n + 1));
        term = (term * theta) >> 30;
        term = (term * theta) >> 30;
        term = udiv64(term + (d >> 1), d);
        if ((n % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > (64'd1 << 30)) begin
        sum = 64'd1 << 30;
      end
      rom[k*ROM_W +: ROM_W] = ROM_W'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
    end
    return rom;
  endfunction

  localparam logic [ROM_SIZE*ROM_W-1:0] SINE_ROM = sine_rom_init();

endpackage

// ----- rtl/stepped_sine_sweep_generator_top.sv -----
// ----------------------------------------------------------------------------
// stepped_sine_sweep_generator_top
// Stepped sine sweep generator: step table in RAM, phase accumulator, sine
// lookup and amplitude scaling.
// ----------------------------------------------------------------------------
// The block takes one request per clock, whatever its op, and holds its input
// only while both pipeline stages carry samples the receiver has not taken;
// a tick's sample passes the table lookup stage, then the amplitude multiply
// into the output register. The step table RAM is read every cycle at the step
// that the next request will see, so back-to-back ticks and one-sample steps
// run at full rate; a write to the entry being read is forwarded. Load the
// table with write requests, set step_count and amplitude, send a restart, then
// tick. Configuration writes are to be made only while no request is in
// flight; the block itself does not enforce this.
module stepped_sine_sweep_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: step_slot[11:0], phase_increment[43:12], step_length[67:44]
  input  logic [sssg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: op[1:0]
  input  logic [sssg_pkg::OP_W-1:0]           s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: sample[15:0], step_number[28:16]
  output logic [sssg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tuser: sweep_done[0]
  output logic [0:0]                          m_axis_tuser,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sssg_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [sssg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned LB = sssg_pkg::LENGTH_BITS;
  localparam int unsigned CW = sssg_pkg::COUNT_W;
  localparam int unsigned AW = sssg_pkg::STEP_ADDR_W;

  // configuration
  logic [sssg_pkg::AMP_W-1:0] amp_q;
  logic [CW-1:0]              step_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q        <= sssg_pkg::AMP_RESET;
      step_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        sssg_pkg::REG_AMPLITUDE:  amp_q        <= cfg_data_i[sssg_pkg::AMP_W-1:0];
        sssg_pkg::REG_STEP_COUNT: step_count_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [sssg_pkg::SLOT_W-1:0] in_slot;
  logic [sssg_pkg::INC_W-1:0]  in_inc;
  logic [sssg_pkg::SLEN_W-1:0] in_len;
  sssg_pkg::op_e               in_op;

  assign in_slot = s_axis_tdata[11:0];
  assign in_inc  = s_axis_tdata[43:12];
  assign in_len  = s_axis_tdata[67:44];
  assign in_op   = sssg_pkg::op_e'(s_axis_tuser);

  // handshake
  logic s1_valid_q;
  logic out_valid_q;
  logic out_ready;
  logic s1_ready;
  logic in_acc;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;
  assign in_acc        = s_axis_tvalid && s1_ready;

  // sweep state
  logic [sssg_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [CW-1:0]                step_q, step_d;
  logic [LB-1:0]                pos_q, pos_d;
  logic [sssg_pkg::INC_W-1:0]   inc_q, inc_d;
  logic                         inc_load_q, inc_load_d;

  // step table
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  sssg_pkg::step_entry_t        ram_wdata;
  sssg_pkg::step_entry_t        ram_rdata;
  logic                         fwd_q;
  sssg_pkg::step_entry_t        fwd_data_q;
  sssg_pkg::step_entry_t        entry;

  assign ram_we          = in_acc && (in_op == sssg_pkg::OP_WRITE) &&
                           ({1'b0, in_slot} < (sssg_pkg::SLOT_W + 1)'(sssg_pkg::STEP_DEPTH));
  assign ram_waddr       = in_slot[AW-1:0];
  assign ram_wdata.inc   = in_inc;
  assign ram_wdata.len   = in_len[LB-1:0];
  assign ram_raddr       = step_d[AW-1:0];

  sssg_ram #(
    .WIDTH (sssg_pkg::ENTRY_W),
    .DEPTH (sssg_pkg::STEP_DEPTH)
  ) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= ram_wdata;
  end

  assign entry = fwd_q ? fwd_data_q : ram_rdata;

  // step logic
  logic [CW-1:0]              count;
  logic [sssg_pkg::INC_W-1:0] inc_eff;
  logic [LB:0]                len_eff;
  logic [LB:0]                pos_next;
  logic [CW-1:0]              step_inc;
  logic                       is_tick;
  logic                       done_now;
  logic                       last;
  logic                       done_after;

  assign count    = (step_count_q > CW'(sssg_pkg::STEP_DEPTH)) ?
                    CW'(sssg_pkg::STEP_DEPTH) : step_count_q;
  assign inc_eff  = inc_load_q ? entry.inc : inc_q;
  assign len_eff  = (entry.len == '0) ? (LB + 1)'(1) : {1'b0, entry.len};
  assign pos_next = {1'b0, pos_q} + (LB + 1)'(1);
  assign step_inc = step_q + CW'(1);
  assign is_tick  = in_acc && (in_op == sssg_pkg::OP_TICK);
  assign done_now = step_q >= count;

  always_comb begin
    phase_d    = phase_q;
    step_d     = step_q;
    pos_d      = pos_q;
    inc_d      = inc_eff;
    inc_load_d = 1'b0;
    last       = 1'b0;
    if (in_acc && (in_op == sssg_pkg::OP_RESTART)) begin
      phase_d    = '0;
      step_d     = '0;
      pos_d      = '0;
      inc_load_d = (count != '0);
      if (count == '0) begin
        inc_d = '0;
      end
    end else if (is_tick && !done_now) begin
      phase_d = phase_q + inc_eff;
      if (pos_next >= len_eff) begin
        last       = 1'b1;
        pos_d      = '0;
        step_d     = step_inc;
        inc_load_d = step_inc < count;
      end else begin
        pos_d = pos_next[LB-1:0];
      end
    end
  end

  assign done_after = step_d >= count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      step_q     <= '0;
      pos_q      <= '0;
      inc_q      <= '0;
      inc_load_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      step_q     <= step_d;
      pos_q      <= pos_d;
      inc_q      <= inc_d;
      inc_load_q <= inc_load_d;
    end
  end

  // lookup stage
  logic [1:0]                          quad;
  logic [sssg_pkg::SINE_TABLE_BITS-1:0] rom_idx;
  logic [sssg_pkg::ROM_W-1:0]          s1_rom_q;
  logic                                s1_neg_q;
  logic                                s1_zero_q;
  logic [CW-1:0]                       s1_step_q;
  logic                                s1_last_q;
  logic                                s1_done_q;

  assign quad    = phase_q[31:30];
  assign rom_idx = quad[0] ? ~phase_q[29 -: sssg_pkg::SINE_TABLE_BITS]
                           :  phase_q[29 -: sssg_pkg::SINE_TABLE_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (is_tick) begin
      s1_valid_q <= 1'b1;
    end else if (out_ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_tick) begin
      s1_rom_q  <= sssg_pkg::SINE_ROM[32'(rom_idx) * sssg_pkg::ROM_W +: sssg_pkg::ROM_W];
      s1_neg_q  <= quad[1];
      s1_zero_q <= done_now;
      s1_step_q <= step_q;
      s1_last_q <= last;
      s1_done_q <= done_now || done_after;
    end
  end

  // scaling stage
  logic [31:0]                  prod;
  logic [sssg_pkg::SAMPLE_W-1:0] mag;
  logic [sssg_pkg::SAMPLE_W-1:0] sample;
  logic [sssg_pkg::SAMPLE_W-1:0] out_sample_q;
  logic [CW-1:0]                out_step_q;
  logic                         out_last_q;
  logic                         out_done_q;

  assign prod   = 32'(s1_rom_q) * 32'(amp_q) + 32'd16384;
  assign mag    = prod[30:15];
  assign sample = s1_zero_q ? '0 : (s1_neg_q ? (~mag + 16'd1) : mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_sample_q <= sample;
      out_step_q   <= s1_step_q;
      out_last_q   <= s1_last_q;
      out_done_q   <= s1_done_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_step_q, out_sample_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

endmodule

// ----- rtl/sssg_ram.sv -----
// ----------------------------------------------------------------------------
// sssg_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read-first output.
// ----------------------------------------------------------------------------
module sssg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/sssg_checker.sv -----
// ----------------------------------------------------------------------------
// sssg_checker
// Port-level assertions for the stepped sine sweep generator, bound to the
// top level.
// ----------------------------------------------------------------------------
module sssg_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [sssg_pkg::OP_W-1:0]           s_axis_tuser,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [sssg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic [0:0]                          m_axis_tuser,
  input  logic                                m_axis_tlast,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready
);

  logic tick_req;

  assign tick_req = s_axis_tvalid && s_axis_tready &&
                    (s_axis_tuser == sssg_pkg::OP_TICK);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a result appears only from an accepted tick request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(tick_req, 2))
    else $error("result without tick request");

  // past the sweep, samples are silent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast |-> m_axis_tdata[15:0] == 16'h0000)
    else $error("nonzero sample after sweep");

  // a step that ends lies inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[28])
    else $error("step end beyond table depth");

endmodule

bind stepped_sine_sweep_generator_top sssg_checker u_sssg_checker (.*);

// ----- test/stepped_sine_sweep_generator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepped_sine_sweep_generator_top_tb
// Self-checking bench for the stepped sine sweep generator. A directed pass
// covers the field extremes and the corner cases of step handling, a
// backpressure pass fills the pipeline against a stalled receiver, and
// random sweeps run under several gain and step count settings. Every
// sample is checked against an in-bench model of the sweep.
// ----------------------------------------------------------------------------
module stepped_sine_sweep_generator_top_tb;

  typedef struct packed {
    logic [sssg_pkg::SAMPLE_W-1:0] sample;
    logic [sssg_pkg::COUNT_W-1:0]  step_number;
    logic                          step_last;
    logic                          sweep_done;
  } sample_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic [sssg_pkg::IN_DATA_W-1:0]    s_tdata;
  logic [sssg_pkg::OP_W-1:0]         s_tuser;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [sssg_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic [0:0]                        m_tuser;
  logic                              m_tlast;
  logic                              m_tvalid;
  logic                              m_tready;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [sssg_pkg::CFG_ADDR_W-1:0]   cfg_addr;
  logic [sssg_pkg::CFG_DATA_W-1:0]   cfg_data;

  // sweep model state
  logic [sssg_pkg::ROM_W-1:0]       sine_lut [sssg_pkg::ROM_SIZE];
  logic [sssg_pkg::INC_W-1:0]       tbl_inc [sssg_pkg::STEP_DEPTH];
  logic [sssg_pkg::LENGTH_BITS-1:0] tbl_len [sssg_pkg::STEP_DEPTH];
  bit                               tbl_written [sssg_pkg::STEP_DEPTH];
  logic [sssg_pkg::PHASE_W-1:0]     phase_acc;
  int unsigned                      sweep_step;
  int unsigned                      step_pos;
  logic [sssg_pkg::INC_W-1:0]       step_inc;
  logic [sssg_pkg::AMP_W-1:0]       amp_reg;
  logic [sssg_pkg::COUNT_W-1:0]     count_reg;

  sample_t     expected_samples [$];
  int unsigned errors;
  int unsigned requests_sent;
  int unsigned samples_checked;
  int unsigned settings_used;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;

  stepped_sine_sweep_generator_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned active_count();
    return (count_reg > sssg_pkg::STEP_DEPTH) ? sssg_pkg::STEP_DEPTH : int'(count_reg);
  endfunction

  function automatic logic [sssg_pkg::SAMPLE_W-1:0] scaled_sine(
      input logic [sssg_pkg::PHASE_W-1:0] ph);
    logic [sssg_pkg::SINE_TABLE_BITS-1:0] idx;
    logic [31:0]                          mag;
    idx = ph[29 -: sssg_pkg::SINE_TABLE_BITS];
    if (ph[30]) begin
      idx = ~idx;
    end
    mag = (32'(sine_lut[idx]) * 32'(amp_reg) + 32'd16384) >> 15;
    return ph[31] ? sssg_pkg::SAMPLE_W'(-mag) : sssg_pkg::SAMPLE_W'(mag);
  endfunction

  task automatic predict_sweep(input sssg_pkg::op_e op,
                               input logic [sssg_pkg::SLOT_W-1:0] slot,
                               input logic [sssg_pkg::INC_W-1:0] inc,
                               input logic [sssg_pkg::SLEN_W-1:0] len);
    int unsigned act;
    int unsigned eff_len;
    sample_t     s;
    act = active_count();
    case (op)
      sssg_pkg::OP_WRITE: begin
        tbl_inc[slot]     = inc;
        tbl_len[slot]     = len[sssg_pkg::LENGTH_BITS-1:0];
        tbl_written[slot] = 1'b1;
      end
      sssg_pkg::OP_RESTART: begin
        phase_acc  = '0;
        sweep_step = 0;
        step_pos   = 0;
        step_inc   = (act > 0) ? tbl_inc[0] : '0;
      end
      sssg_pkg::OP_TICK: begin
        if (sweep_step >= act) begin
          s = '{sample: '0, step_number: sssg_pkg::COUNT_W'(sweep_step), step_last: 1'b0,
                sweep_done: 1'b1};
        end else begin
          eff_len = (tbl_len[sweep_step] == 0) ? 1 : int'(tbl_len[sweep_step]);
          s.sample      = scaled_sine(phase_acc);
          s.step_number = sssg_pkg::COUNT_W'(sweep_step);
          s.step_last   = 1'b0;
          phase_acc     = phase_acc + step_inc;
          step_pos++;
          if (step_pos >= eff_len) begin
            s.step_last = 1'b1;
            step_pos    = 0;
            sweep_step++;
            if (sweep_step < act) begin
              step_inc = tbl_inc[sweep_step];
            end
          end
          s.sweep_done = (sweep_step >= act);
        end
        expected_samples = {expected_samples, s};
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input sssg_pkg::op_e op,
                              input logic [sssg_pkg::SLOT_W-1:0] slot,
                              input logic [sssg_pkg::INC_W-1:0] inc,
                              input logic [sssg_pkg::SLEN_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, len, inc, slot};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predict_sweep(op, slot, inc, len);
    if (op != sssg_pkg::OP_NONE) begin
      requests_sent++;
    end
  endtask

  function automatic logic [sssg_pkg::INC_W-1:0] random_inc();
    logic [sssg_pkg::INC_W-1:0] r;
    r     = $urandom();
    r[31] = 1'b0;
    return ($urandom_range(15) == 0) ? 32'h8000_0000 : r;
  endfunction

  function automatic logic [sssg_pkg::SLEN_W-1:0] random_length();
    if ($urandom_range(19) == 0) begin
      return sssg_pkg::SLEN_W'($urandom_range(1, 24'hff_ffff));
    end
    return sssg_pkg::SLEN_W'($urandom_range(1, 6));
  endfunction

  task automatic fill_slot(input int unsigned slot);
    send_request(sssg_pkg::OP_WRITE, sssg_pkg::SLOT_W'(slot), random_inc(),
                 sssg_pkg::SLEN_W'($urandom_range(1, 4)));
  endtask

  // entries that the tick will read are loaded first
  task automatic send_tick();
    int unsigned act;
    int unsigned eff_len;
    act = active_count();
    if (sweep_step < act) begin
      if (!tbl_written[sweep_step]) begin
        fill_slot(sweep_step);
      end
      eff_len = (tbl_len[sweep_step] == 0) ? 1 : int'(tbl_len[sweep_step]);
      if (step_pos + 1 >= eff_len && sweep_step + 1 < act && !tbl_written[sweep_step + 1]) begin
        fill_slot(sweep_step + 1);
      end
    end
    send_request(sssg_pkg::OP_TICK, sssg_pkg::SLOT_W'($urandom()), $urandom(),
                 sssg_pkg::SLEN_W'($urandom()));
  endtask

  task automatic send_restart();
    if (active_count() > 0 && !tbl_written[0]) begin
      fill_slot(0);
    end
    send_request(sssg_pkg::OP_RESTART, sssg_pkg::SLOT_W'($urandom()), $urandom(),
                 sssg_pkg::SLEN_W'($urandom()));
  endtask

  task automatic send_idle_op();
    send_request(sssg_pkg::OP_NONE, sssg_pkg::SLOT_W'($urandom()), $urandom(),
                 sssg_pkg::SLEN_W'($urandom()));
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(input sssg_pkg::reg_e idx,
                                input logic [sssg_pkg::CFG_DATA_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sssg_pkg::REG_AMPLITUDE:  amp_reg = value[sssg_pkg::AMP_W-1:0];
      sssg_pkg::REG_STEP_COUNT: count_reg = value[sssg_pkg::COUNT_W-1:0];
      default: ;
    endcase
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_idle_pct = 10;
    recv_idle_pct = 66;
    // empty table, tick reports done
    send_tick();
    send_idle_op();
    send_request(sssg_pkg::OP_WRITE, 12'd0, 32'h8000_0000, 24'd0);
    send_request(sssg_pkg::OP_WRITE, 12'd1, 32'h4000_0000, 24'hff_ffff);
    send_request(sssg_pkg::OP_WRITE, 12'hfff, 32'h7fff_ffff, 24'd1);
    send_request(sssg_pkg::OP_WRITE, 12'd2, 32'h0000_0000, 24'd2);
    write_register(sssg_pkg::REG_STEP_COUNT, 16'd3);
    // ticks before any restart, then all four quadrants
    repeat (5) send_tick();
    // shorten the running step
    send_request(sssg_pkg::OP_WRITE, 12'd1, 32'h4000_0000, 24'd6);
    repeat (5) send_tick();
    send_restart();
    repeat (2) send_tick();
    write_register(sssg_pkg::REG_STEP_COUNT, 16'd8191);
    write_register(sssg_pkg::REG_AMPLITUDE, 16'd0);
    send_tick();
    // count dropped below the running step, then raised again
    write_register(sssg_pkg::REG_STEP_COUNT, 16'd1);
    send_tick();
    write_register(sssg_pkg::REG_STEP_COUNT, 16'd3);
    write_register(sssg_pkg::REG_AMPLITUDE, 16'd1);
    send_tick();
    write_register(sssg_pkg::REG_STEP_COUNT, 16'd0);
    send_restart();
    send_tick();
    write_register(sssg_pkg::REG_AMPLITUDE, 16'h7fff);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(sssg_pkg::REG_STEP_COUNT, 16'd4);
    for (int i = 0; i < 4; i++) begin
      fill_slot(i);
    end
    send_restart();
    hold_left = 300;
    repeat (60) send_tick();
    drain();
    repeat (20) send_tick();
    drain();
  endtask

  task automatic test_random_sweeps();
    int unsigned target;
    int unsigned pick;
    logic [sssg_pkg::CFG_DATA_W-1:0] amp_val;
    logic [sssg_pkg::CFG_DATA_W-1:0] count_val;
    for (int p = 0; p < 10; p++) begin
      send_idle_pct = (p < 4) ? 10 : (p < 7) ? 66 : 0;
      recv_idle_pct = (p < 4) ? 66 : (p < 7) ? 10 : 0;
      case (p)
        0:       amp_val = 16'h7fff;
        1:       amp_val = 16'd0;
        9:       amp_val = 16'd1;
        default: amp_val = sssg_pkg::CFG_DATA_W'($urandom_range(0, 32767));
      endcase
      case (p)
        2:       count_val = 16'd1;
        4:       count_val = 16'd0;
        7:       count_val = 16'd8191;
        default: count_val = sssg_pkg::CFG_DATA_W'($urandom_range(1, 24));
      endcase
      write_register(sssg_pkg::REG_AMPLITUDE, amp_val);
      write_register(sssg_pkg::REG_STEP_COUNT, count_val);
      send_restart();
      target = requests_sent + 170;
      while (requests_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 62) begin
          send_tick();
        end else if (pick < 80) begin
          send_request(sssg_pkg::OP_WRITE,
                       sssg_pkg::SLOT_W'($urandom_range(active_count() + 1)),
                       random_inc(), random_length());
        end else if (pick < 86) begin
          send_request(sssg_pkg::OP_WRITE, sssg_pkg::SLOT_W'($urandom()), random_inc(),
                       random_length());
        end else if (pick < 93) begin
          send_restart();
        end else if (pick < 96) begin
          send_idle_op();
        end else begin
          send_tick();
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected sample: got %0d", $signed(m_tdata[15:0]));
        errors++;
      end else begin
        exp_s = expected_samples.pop_front();
        samples_checked++;
        if (m_tdata[15:0] !== exp_s.sample) begin
          $error("sample: expected %0d, got %0d", $signed(exp_s.sample),
                 $signed(m_tdata[15:0]));
          errors++;
        end
        if (m_tdata[28:16] !== exp_s.step_number) begin
          $error("step_number: expected %0d, got %0d", exp_s.step_number, m_tdata[28:16]);
          errors++;
        end
        if (m_tlast !== exp_s.step_last) begin
          $error("step_last: expected %0b, got %0b", exp_s.step_last, m_tlast);
          errors++;
        end
        if (m_tuser[0] !== exp_s.sweep_done) begin
          $error("sweep_done: expected %0b, got %0b", exp_s.sweep_done, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [63:0] theta;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] d;
    rst_n         = 1'b0;
    s_tdata       = '0;
    s_tuser       = sssg_pkg::OP_NONE;
    s_tvalid      = 1'b0;
    m_tready      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_addr      = sssg_pkg::REG_AMPLITUDE;
    cfg_data      = '0;
    errors        = 0;
    requests_sent = 0;
    samples_checked = 0;
    settings_used = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    phase_acc     = '0;
    sweep_step    = 0;
    step_pos      = 0;
    step_inc      = '0;
    amp_reg       = 15'h7fff;
    count_reg     = '0;
    for (int i = 0; i < sssg_pkg::STEP_DEPTH; i++) begin
      tbl_inc[i]     = '0;
      tbl_len[i]     = '0;
      tbl_written[i] = 1'b0;
    end
    // quarter-wave midpoints from a q30 taylor series
    for (int k = 0; k < sssg_pkg::ROM_SIZE; k++) begin
      theta = (64'd1686629713 * (64'(2 * k) + 64'd1) + 64'(sssg_pkg::ROM_SIZE)) /
              64'(2 * sssg_pkg::ROM_SIZE);
      term  = theta;
      sum   = theta;
      for (int n = 1; n <= 10; n++) begin
        d    = 64'((2 * n) * (2 * n + 1));
        term = (term * theta) >> 30;
        term = (term * theta) >> 30;
        term = (term + d / 2) / d;
        if (n % 2 == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > (64'd1 << 30)) begin
        sum = 64'd1 << 30;
      end
      sine_lut[k] = sssg_pkg::ROM_W'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_sweeps();
    drain();

    $display("run: %0d requests sent, %0d samples checked", requests_sent, samples_checked);
    $display("run: %0d register writes, backpressure and idle mixes exercised", settings_used);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
